// ----- design/dlps_pkg.sv -----
`timescale 1ns / 1ps

package dlps_pkg;

    // Sample and phase formats
    localparam int SAMPLE_W         = 16;
    localparam int PHASE_BITS       = 24;
    localparam int STEP_W           = 18;
    localparam int WINDOW_W         = 12;
    localparam int FRAC_W           = 16;
    // Distance between the two taps, in delay units: window << HALF_SHIFT
    localparam int HALF_SHIFT       = PHASE_BITS - 1 - (PHASE_BITS - FRAC_W);

    // Gain table, sin^2(pi*k/N) in Q16
    localparam int GAIN_TABLE_DEPTH = 256;
    localparam int GAIN_IDX_W       = $clog2(GAIN_TABLE_DEPTH);
    localparam int GAIN_W           = 17;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W          = 33;
    localparam int MUL_B_W          = 18;
    localparam int PROD_W           = MUL_A_W + MUL_B_W;

    // Interpolated tap, sample scaled by 2^16
    localparam int TAP_W            = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd1;

    localparam logic [STEP_W-1:0]   STEP_RESET   = '0;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 12'd960;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'd1073741824;

    typedef logic [GAIN_W-1:0] t_gain_table [GAIN_TABLE_DEPTH];

    // Integer Taylor series of sin up to theta^13, squared, rounded to Q16
    function automatic t_gain_table build_gain_table();
        t_gain_table     tbl;
        longint unsigned u;
        longint unsigned theta;
        longint unsigned th2;
        longint unsigned term;
        longint unsigned s2;
        longint unsigned g;
        longint          sum;
        for (int k = 0; k < GAIN_TABLE_DEPTH; k++) begin
            u = longint'(k);
            if (2 * k > GAIN_TABLE_DEPTH) begin
                u = longint'(GAIN_TABLE_DEPTH - k);
            end
            theta = (PI_Q30 * u) / GAIN_TABLE_DEPTH;
            th2   = (theta * theta) >> 30;
            term  = theta;
            sum   = longint'(theta);
            for (int n = 1; n <= 6; n++) begin
                term = (term * th2) >> 30;
                unique case (n)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    default: term = term / 64'd156;
                endcase
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > ONE_Q30) begin
                sum = ONE_Q30;
            end
            s2 = (longint'(sum) * longint'(sum)) >> 30;
            g  = (s2 + 64'd8192) >> 14;
            if (g > 64'd65536) begin
                g = 64'd65536;
            end
            tbl[k] = GAIN_W'(g);
        end
        return tbl;
    endfunction

    localparam t_gain_table GAIN_TABLE = build_gain_table();

endpackage

// ----- design/delay_line_pitch_shifter_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Beat content (low bit up)
// s_axis    in   tvalid tready tdata[15:0]       sample_in (Q1.15)
// m_axis    out  tvalid tready tdata[15:0]       sample_out (Q1.15, saturated)
// cfg       in   i_cfg_we i_cfg_index i_cfg_data 0: phase_step, 1: window_samples
//
// Sequence: an accepted beat steps through ST_ADDR, ST_RD_B1, ST_RD_A2,
// ST_RD_B2, ST_TAP2, ST_SUM2 and ST_MIX to ST_DONE, which loads the output
// register; a new beat is accepted only back in idle. The shared multiplier
// (delay, two taps, crossfade) and single RAM read port (four tap reads) force it.
// Reset: i_rst_n is synchronous, active low. The delay RAM is not swept; a
// fill flag and the write pointer mark entries never written, which read as 0.
// Stalls: s_axis_tready is high only in the idle state. A finished result
// waits in the output register; a second result stays in the last step, with
// the multiplier holding the crossfade product, until that register is free.
module delay_line_pitch_shifter_unit #(
    parameter int BUFFER_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample_in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,
    // sample_out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [dlps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dlps_pkg::STEP_W-1:0]       i_cfg_data
);
    import dlps_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    // Read position: integer part AW bits, fraction FRAC_W bits
    localparam int PW = AW + FRAC_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ADDR  = 9'b000000010,
        ST_RD_B1 = 9'b000000100,
        ST_RD_A2 = 9'b000001000,
        ST_RD_B2 = 9'b000010000,
        ST_TAP2  = 9'b000100000,
        ST_SUM2  = 9'b001000000,
        ST_MIX   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    t_state                     r_state, n_state;
    logic [STEP_W-1:0]          r_step;
    logic [WINDOW_W-1:0]        r_window;
    logic [PHASE_BITS-1:0]      r_phase;
    logic [AW-1:0]              r_wp;
    logic                       r_full;
    logic [PW-1:0]              r_pos1, r_pos2;
    logic signed [SAMPLE_W-1:0] r_a1, r_a2;
    logic signed [TAP_W-1:0]    r_t1, r_t2;
    logic                       r_rd_ok;
    logic [SAMPLE_W-1:0]        r_out;
    logic                       r_ov;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic [AW-1:0]              rd_addr;
    logic [SAMPLE_W-1:0]        rd_raw;
    logic signed [SAMPLE_W-1:0] rd_data;

    logic [PW-1:0]              dly1, dly2, half_w, wp_fix, pos1, pos2;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [TAP_W:0]      tap_sum;
    logic signed [TAP_W:0]      t_diff;
    logic [GAIN_W-1:0]          gain;
    logic signed [PROD_W-1:0]   y_sum, y_rnd;
    logic signed [PROD_W-33:0]  y_q;
    logic [SAMPLE_W-1:0]        y_sat;
    logic                       in_go, done_go;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_go         = s_axis_tvalid && s_axis_tready;
    assign done_go       = (r_state == ST_DONE) && (!r_ov || m_axis_tready);

    // Tap delays: first from the product, second half a window away
    assign dly1   = prod[(PHASE_BITS - FRAC_W) +: PW];
    assign half_w = PW'({r_window, {HALF_SHIFT{1'b0}}});
    assign dly2   = r_phase[PHASE_BITS-1] ? (dly1 - half_w) : (dly1 + half_w);
    assign wp_fix = {r_wp, {FRAC_W{1'b0}}};
    assign pos1   = wp_fix - dly1;
    assign pos2   = wp_fix - dly2;

    // Entries never written read as zero
    assign rd_data = r_rd_ok ? $signed(rd_raw) : '0;
    assign diff    = (SAMPLE_W + 1)'(rd_data) - (SAMPLE_W + 1)'(r_a1);
    assign gain    = GAIN_TABLE[r_phase[PHASE_BITS-1 -: GAIN_IDX_W]];
    assign t_diff  = (TAP_W + 1)'(r_t1) - (TAP_W + 1)'(r_t2);

    // Read address and multiplier operand select
    always_comb begin
        rd_addr = r_pos1[PW-1:FRAC_W];
        mul_a   = MUL_A_W'(r_phase);
        mul_b   = MUL_B_W'(r_window);
        unique case (r_state)
            ST_IDLE: begin
                mul_a = MUL_A_W'(r_phase);
                mul_b = MUL_B_W'(r_window);
            end
            ST_ADDR: begin
                rd_addr = pos1[PW-1:FRAC_W];
            end
            ST_RD_B1: begin
                rd_addr = r_pos1[PW-1:FRAC_W] + 1'b1;
            end
            ST_RD_A2: begin
                rd_addr = r_pos2[PW-1:FRAC_W];
                mul_a   = MUL_A_W'(diff);
                mul_b   = MUL_B_W'(r_pos1[FRAC_W-1:0]);
            end
            ST_RD_B2: begin
                rd_addr = r_pos2[PW-1:FRAC_W] + 1'b1;
            end
            ST_TAP2: begin
                mul_a = MUL_A_W'((SAMPLE_W + 1)'(rd_data) - (SAMPLE_W + 1)'(r_a2));
                mul_b = MUL_B_W'(r_pos2[FRAC_W-1:0]);
            end
            ST_SUM2: begin
            end
            // Hold the crossfade operands while the result waits
            ST_MIX, ST_DONE: begin
                mul_a = MUL_A_W'(t_diff);
                mul_b = MUL_B_W'(gain);
            end
            default: begin
            end
        endcase
    end

    // Tap: a*2^16 + (b-a)*f, the product holds (b-a)*f
    assign tap_sum = (TAP_W + 1)'({r_a1, {FRAC_W{1'b0}}}) + (TAP_W + 1)'(prod);

    // Crossfade: t2*2^16 + (t1-t2)*g, round half up, drop 32 fraction bits
    assign y_sum = (PROD_W'(r_t2) <<< FRAC_W) + prod;
    assign y_rnd = y_sum + (PROD_W'(1) <<< 31);
    assign y_q   = y_rnd[PROD_W-1:32];

    always_comb begin
        if (y_q[PROD_W-33:SAMPLE_W-1] == '0 || y_q[PROD_W-33:SAMPLE_W-1] == '1) begin
            y_sat = y_q[SAMPLE_W-1:0];
        end else if (y_q[PROD_W-33]) begin
            y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_go) n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_RD_B1;
            ST_RD_B1: n_state = ST_RD_A2;
            ST_RD_A2: n_state = ST_RD_B2;
            ST_RD_B2: n_state = ST_TAP2;
            ST_TAP2:  n_state = ST_SUM2;
            ST_SUM2:  n_state = ST_MIX;
            ST_MIX:   n_state = ST_DONE;
            ST_DONE:  if (done_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STEP_RESET;
            r_window <= WINDOW_RESET;
            r_phase  <= '0;
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PHASE_STEP) begin
                    r_step <= i_cfg_data;
                end else if (i_cfg_index == CFG_WINDOW) begin
                    r_window <= i_cfg_data[WINDOW_W-1:0];
                end
            end
            // Advance pointer and phase once the result is loaded
            if (done_go) begin
                r_wp    <= r_wp + 1'b1;
                r_phase <= r_phase + PHASE_BITS'($signed(r_step));
                if (&r_wp) begin
                    r_full <= 1'b1;
                end
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_full || (rd_addr <= r_wp);
        if (r_state == ST_ADDR) begin
            r_pos1 <= pos1;
            r_pos2 <= pos2;
        end
        if (r_state == ST_RD_B1) begin
            r_a1 <= rd_data;
        end
        if (r_state == ST_RD_B2) begin
            r_a2 <= rd_data;
            r_t1 <= tap_sum[TAP_W-1:0];
        end
        if (r_state == ST_SUM2) begin
            r_t2 <= TAP_W'((TAP_W + 1)'({r_a2, {FRAC_W{1'b0}}}) + (TAP_W + 1)'(prod));
        end
        if (done_go) begin
            r_out <= y_sat;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    dlps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_go),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata[SAMPLE_W-1:0]),
        .i_raddr (rd_addr),
        .o_rdata (rd_raw)
    );

    dlps_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_ADDR))
        else $error("accepted beat did not start processing");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_go |=> (m_axis_tvalid && r_wp == $past(r_wp) + 1'b1))
        else $error("result not loaded or pointer not advanced");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result overwritten");

endmodule

// ----- design/dlps_ram.sv -----
`timescale 1ns / 1ps

module dlps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dlps_mul.sv -----
`timescale 1ns / 1ps

// Shared signed multiplier, product registered
module dlps_mul (
    input  logic                                i_clk,
    input  logic signed [dlps_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [dlps_pkg::MUL_B_W-1:0] i_b,
    output logic signed [dlps_pkg::PROD_W-1:0]  o_p
);
    import dlps_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
